// ===== src/button_press_event_classifier_top_defines.svh =====
// Assertion macros for the button press event classifier.
`ifndef BUTTON_PRESS_EVENT_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_PRESS_EVENT_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BPEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BPEC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define BPEC_ASSERT(lbl, prop, msg)
`define BPEC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== src/bpec_pkg.sv =====
package bpec_pkg;

	localparam int NUM_BUTTONS = 16;
	localparam int MASK_W      = 16;
	localparam int SCAN_COUNT  = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;
	localparam int SCAN_IDX_W  = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;
	localparam int BTN_W       = 4;
	localparam int TIME_W      = 32;
	localparam int WIN_W       = 16;

	localparam int EV_MAX   = 3;
	localparam int EV_CNT_W = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MASK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_MASK   = 2'd2;

	localparam logic [WIN_W-1:0] DOUBLE_WINDOW_RST = 16'd250;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_DOUBLE  = 2'd1,
		EV_HOLD    = 2'd2,
		EV_RELEASE = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic              cmd;
		logic [MASK_W-1:0] button_levels;
		logic [TIME_W-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [BTN_W-1:0] button_index;
		ev_kind_t         event_kind;
		logic             last_event;
	} out_t;

	typedef struct packed {
		logic [WIN_W-1:0]  double_window_ms;
		logic [MASK_W-1:0] bound_mask;
		logic [MASK_W-1:0] double_mask;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic hold_valid;
	} scan_status_t;

endpackage

// ===== src/bpec_fifo.sv =====
module bpec_fifo import bpec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  out_t push_data,
	output logic full,
	input  logic pop,
	output out_t pop_data,
	output logic empty
);

	out_t                  entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/bpec_scan.sv =====
module bpec_scan import bpec_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         push,
	input  in_t          item,
	output logic         q_push,
	output out_t         q_data,
	input  logic         q_full,
	output scan_status_t status
);

	typedef enum logic [3:0] {
		SQ_IDLE = 4'b0001,
		SQ_SCAN = 4'b0010,
		SQ_EMIT = 4'b0100,
		SQ_FIN  = 4'b1000
	} seq_state_t;

	typedef enum logic [2:0] {
		TRK_IDLE = 3'b001,
		TRK_BUF  = 3'b010,
		TRK_DISP = 3'b100
	} trk_state_t;

	seq_state_t            seq_q;
	logic                  cmd_q;
	logic [MASK_W-1:0]     levels_q;
	logic [TIME_W-1:0]     now_q;
	logic [SCAN_IDX_W-1:0] idx_q;
	ev_kind_t              evk_q [EV_MAX];
	logic [EV_CNT_W-1:0]   evn_q;
	logic [EV_CNT_W-1:0]   ptr_q;
	logic                  hold_valid_q;
	out_t                  hold_q;

	trk_state_t            trk_q   [SCAN_COUNT];
	logic                  down_q  [SCAN_COUNT];
	logic [TIME_W-1:0]     ptime_q [SCAN_COUNT];

	trk_state_t            st;
	trk_state_t            nst;
	logic                  prev;
	logic                  pressed;
	logic                  bound;
	logic                  dbl;
	logic                  rise;
	logic [TIME_W-1:0]     diff;
	logic                  exp_old;
	logic                  exp_zero;
	logic                  exp_fin;
	logic                  set_time;
	ev_kind_t              kinds [EV_MAX];
	logic [EV_CNT_W-1:0]   n_ev;
	logic                  last_idx;
	logic                  emit_go;
	logic                  trk_wr;
	logic                  trk_clr;

	assign st       = trk_q[idx_q];
	assign prev     = down_q[idx_q];
	assign pressed  = levels_q[idx_q];
	assign bound    = cfg.bound_mask[idx_q];
	assign dbl      = cfg.double_mask[idx_q];
	assign rise     = pressed && !prev;
	assign diff     = now_q - ptime_q[idx_q];
	// negative elapsed time counts as expired
	assign exp_old  = !dbl || diff[TIME_W-1] ||
		(diff[TIME_W-2:0] >= (TIME_W-1)'(cfg.double_window_ms));
	assign exp_zero = !dbl || (cfg.double_window_ms == '0);
	assign last_idx = (idx_q == SCAN_IDX_W'(SCAN_COUNT-1));
	assign emit_go  = !hold_valid_q || !q_full;

	always_comb begin
		kinds    = '{default: EV_PRESS};
		n_ev     = '0;
		nst      = st;
		set_time = 1'b0;
		exp_fin  = exp_old;
		if (bound) begin
			if (cmd_q == CMD_FLUSH) begin
				if (st == TRK_DISP) begin
					kinds[0] = EV_RELEASE;
					n_ev     = 2'd1;
				end else if (st == TRK_BUF) begin
					kinds[0] = EV_PRESS;
					kinds[1] = EV_RELEASE;
					n_ev     = 2'd2;
				end
			end else begin
				if (rise) begin
					if (st == TRK_BUF && !exp_old) begin
						nst      = TRK_DISP;
						kinds[0] = EV_DOUBLE;
						n_ev     = 2'd1;
					end else begin
						if (st == TRK_BUF) begin
							kinds[0] = EV_PRESS;
							kinds[1] = EV_RELEASE;
							n_ev     = 2'd2;
						end
						nst      = TRK_BUF;
						set_time = 1'b1;
						exp_fin  = exp_zero;
					end
				end else if (pressed) begin
					if (st == TRK_DISP) begin
						kinds[0] = EV_HOLD;
						n_ev     = 2'd1;
					end
				end else if (prev) begin
					if (st == TRK_DISP) begin
						kinds[0] = EV_RELEASE;
						n_ev     = 2'd1;
						nst      = TRK_IDLE;
					end
				end
				if (nst == TRK_BUF && exp_fin) begin
					kinds[n_ev] = EV_PRESS;
					n_ev        = n_ev + 2'd1;
					if (pressed) begin
						nst = TRK_DISP;
					end else begin
						kinds[n_ev] = EV_RELEASE;
						n_ev        = n_ev + 2'd1;
						nst         = TRK_IDLE;
					end
				end
			end
		end
	end

	assign trk_wr  = (seq_q == SQ_SCAN) && (cmd_q == CMD_SAMPLE) && bound;
	assign trk_clr = (seq_q == SQ_FIN) && (cmd_q == CMD_FLUSH);

	assign q_push = ((seq_q == SQ_EMIT) || (seq_q == SQ_FIN)) && hold_valid_q && !q_full;
	assign q_data = '{button_index: hold_q.button_index,
		event_kind: hold_q.event_kind, last_event: (seq_q == SQ_FIN)};

	assign status = '{busy: (seq_q != SQ_IDLE), hold_valid: hold_valid_q};

	always_ff @(posedge clk) begin
		if (seq_q == SQ_IDLE && push) begin
			cmd_q    <= item.cmd;
			levels_q <= item.button_levels;
			now_q    <= item.now_ms;
		end
		if (seq_q == SQ_SCAN) begin
			evk_q <= kinds;
			evn_q <= n_ev;
		end
		if (trk_wr && set_time) begin
			ptime_q[idx_q] <= now_q;
		end
		if (seq_q == SQ_EMIT && emit_go) begin
			hold_q <= '{button_index: BTN_W'(idx_q), event_kind: evk_q[ptr_q],
				last_event: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SQ_IDLE;
			idx_q        <= '0;
			ptr_q        <= '0;
			hold_valid_q <= 1'b0;
			for (int i = 0; i < SCAN_COUNT; i++) begin
				trk_q[i]  <= TRK_IDLE;
				down_q[i] <= 1'b0;
			end
		end else begin
			if (trk_clr) begin
				for (int i = 0; i < SCAN_COUNT; i++) begin
					trk_q[i]  <= TRK_IDLE;
					down_q[i] <= 1'b0;
				end
			end else if (trk_wr) begin
				trk_q[idx_q]  <= nst;
				down_q[idx_q] <= pressed;
			end
			unique case (seq_q)
				SQ_IDLE: begin
					if (push) begin
						idx_q <= '0;
						seq_q <= SQ_SCAN;
					end
				end
				SQ_SCAN: begin
					ptr_q <= '0;
					if (n_ev != '0) begin
						seq_q <= SQ_EMIT;
					end else if (last_idx) begin
						seq_q <= SQ_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				SQ_EMIT: begin
					if (emit_go) begin
						hold_valid_q <= 1'b1;
						if (ptr_q == evn_q - 2'd1) begin
							if (last_idx) begin
								seq_q <= SQ_FIN;
							end else begin
								idx_q <= idx_q + 1'b1;
								seq_q <= SQ_SCAN;
							end
						end else begin
							ptr_q <= ptr_q + 2'd1;
						end
					end
				end
				SQ_FIN: begin
					if (emit_go) begin
						hold_valid_q <= 1'b0;
						seq_q        <= SQ_IDLE;
					end
				end
				default: begin
					seq_q <= SQ_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/button_press_event_classifier_top.sv =====
// Button press event classifier. Each item is scanned one button per cycle
// in ascending order, pausing while a button's events are written; each
// event found (press, double press, hold, release) is written into a
// four-entry result queue at one per cycle while the queue has room, with
// the final event of the item marked by last_event. With 16 buttons an item
// produces 0 to 48 events; the scanner takes no new item until all of them
// are written, and stalls on the result side hold it once the queue is full.
// A flush item releases pending presses of bound buttons and clears every
// tracker. Registers must be written only while full is low and the result
// queue is drained of the previous item's events; the block does not enforce it.
`include "button_press_event_classifier_top_defines.svh"

module button_press_event_classifier_top import bpec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_t                   item,
	output logic                  empty,
	input  logic                  pop,
	output out_t                  result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t         cfg_q;
	scan_status_t scan_stat;
	logic         scan_push;
	out_t         scan_data;
	logic         scan_q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.double_window_ms <= DOUBLE_WINDOW_RST;
			cfg_q.bound_mask       <= '0;
			cfg_q.double_mask      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DOUBLE_WINDOW: cfg_q.double_window_ms <= WIN_W'(cfg_data);
				CFG_BOUND_MASK:    cfg_q.bound_mask       <= MASK_W'(cfg_data);
				CFG_DOUBLE_MASK:   cfg_q.double_mask      <= MASK_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign full = scan_stat.busy;

	bpec_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.item   (item),
		.q_push (scan_push),
		.q_data (scan_data),
		.q_full (scan_q_full),
		.status (scan_stat)
	);

	bpec_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (scan_push),
		.push_data (scan_data),
		.full      (scan_q_full),
		.pop       (pop),
		.pop_data  (result),
		.empty     (empty)
	);

	`BPEC_ASSERT_NEXT(a_busy_after_transfer, push && !full, full, "item taken while scanner idle did not start a scan")
	`BPEC_ASSERT(a_queue_no_overflow, scan_push |-> !scan_q_full, "event written into a full result queue")
	`BPEC_ASSERT(a_idle_hold_empty, !scan_stat.busy |-> !scan_stat.hold_valid, "scanner idle with an event still held back")

endmodule

// ===== verif/button_press_event_classifier_top_test.sv =====
`timescale 1ns / 100ps

module button_press_event_classifier_top_test;
	import bpec_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int LONG_STALL    = 600;

	typedef enum logic [1:0] {
		TRK_IDLE       = 2'd0,
		TRK_BUFFER     = 2'd1,
		TRK_DISPATCHED = 2'd2
	} trk_state_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_t                   item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	out_t                  result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_DOUBLE_WINDOW;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [WIN_W-1:0]  win_ms      = DOUBLE_WINDOW_RST;
	logic [MASK_W-1:0] bound_bits  = '0;
	logic [MASK_W-1:0] double_bits = '0;
	trk_state_t        trk_state    [SCAN_COUNT];
	logic              trk_down     [SCAN_COUNT];
	logic [TIME_W-1:0] trk_press_ms [SCAN_COUNT];
	out_t              item_events    [$];
	out_t              pending_events [$];

	logic [MASK_W-1:0] live_levels = '0;
	logic [TIME_W-1:0] live_ms     = '0;

	int   send_idle_pct  = 0;
	int   stall_pct      = 0;
	int   errors         = 0;
	int   items_sent     = 0;
	int   flushes        = 0;
	int   events_checked = 0;
	int   cycle_count;
	logic stall_hold     = 1'b0;
	event start_long_stall;

	button_press_event_classifier_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial forever #4 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic void clear_trackers();
		for (int b = 0; b < SCAN_COUNT; b++) begin
			trk_state[b]    = TRK_IDLE;
			trk_down[b]     = 1'b0;
			trk_press_ms[b] = '0;
		end
	endfunction

	function automatic logic window_over(int b, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		if (!double_bits[b])
			return 1'b1;
		elapsed = now - trk_press_ms[b];
		if (elapsed[TIME_W-1])
			return 1'b1;
		return elapsed >= win_ms;
	endfunction

	function automatic void note_event(int b, ev_kind_t kind);
		out_t ev;
		ev.button_index = BTN_W'(b);
		ev.event_kind   = kind;
		ev.last_event   = 1'b0;
		item_events = {item_events, ev};
	endfunction

	function automatic void resolve_tap(int b, logic held);
		note_event(b, EV_PRESS);
		if (held) begin
			trk_state[b] = TRK_DISPATCHED;
		end else begin
			note_event(b, EV_RELEASE);
			trk_state[b] = TRK_IDLE;
		end
	endfunction

	function automatic void predict_events(in_t it);
		logic pressed;
		logic prev;
		out_t ev;
		item_events.delete();
		for (int b = 0; b < SCAN_COUNT; b++) begin
			if (bound_bits[b]) begin
				if (it.cmd == CMD_FLUSH) begin
					if (trk_state[b] == TRK_DISPATCHED) begin
						note_event(b, EV_RELEASE);
						trk_state[b] = TRK_IDLE;
					end else if (trk_state[b] == TRK_BUFFER) begin
						resolve_tap(b, 1'b0);
					end
				end else begin
					pressed = it.button_levels[b];
					prev = trk_down[b];
					trk_down[b] = pressed;
					if (pressed && !prev) begin
						if (trk_state[b] == TRK_BUFFER && !window_over(b, it.now_ms)) begin
							trk_state[b] = TRK_DISPATCHED;
							note_event(b, EV_DOUBLE);
						end else begin
							if (trk_state[b] == TRK_BUFFER)
								resolve_tap(b, 1'b0);
							trk_state[b] = TRK_BUFFER;
							trk_press_ms[b] = it.now_ms;
						end
					end else if (pressed) begin
						if (trk_state[b] == TRK_DISPATCHED)
							note_event(b, EV_HOLD);
					end else if (prev) begin
						if (trk_state[b] == TRK_DISPATCHED) begin
							note_event(b, EV_RELEASE);
							trk_state[b] = TRK_IDLE;
						end
					end
					if (trk_state[b] == TRK_BUFFER && window_over(b, it.now_ms))
						resolve_tap(b, pressed);
				end
			end
		end
		if (it.cmd == CMD_FLUSH)
			clear_trackers();
		if (item_events.size() > 0) begin
			ev = item_events[item_events.size() - 1];
			ev.last_event = 1'b1;
			item_events[item_events.size() - 1] = ev;
		end
		pending_events = {pending_events, item_events};
	endfunction

	// ---------------- result side ----------------

	always @(posedge clk) begin
		out_t want;
		if (arst_n && pop && empty === 1'b0) begin
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected event: expected none, actual btn %0d kind %0d last %0d",
					$time, result.button_index, result.event_kind, result.last_event);
			end else begin
				want = pending_events.pop_front();
				events_checked++;
				if (result.button_index !== want.button_index ||
						result.event_kind !== want.event_kind ||
						result.last_event !== want.last_event) begin
					errors++;
					$display("%0t: mismatch: expected btn %0d kind %0d last %0d, actual btn %0d kind %0d last %0d",
						$time, want.button_index, want.event_kind, want.last_event,
						result.button_index, result.event_kind, result.last_event);
				end
			end
		end
		pop <= !stall_hold && ($urandom_range(99) >= stall_pct);
	end

	initial forever begin
		@(start_long_stall);
		stall_hold <= 1'b1;
		repeat (LONG_STALL) @(posedge clk);
		stall_hold <= 1'b0;
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------- input side ----------------

	task automatic send_item(in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full !== 1'b0);
		predict_events(it);
		items_sent++;
	endtask

	task automatic send_sample(logic [MASK_W-1:0] levels, logic [TIME_W-1:0] ms);
		in_t it;
		it.cmd = CMD_SAMPLE;
		it.button_levels = levels;
		it.now_ms = ms;
		live_levels = levels;
		live_ms = ms;
		send_item(it);
	endtask

	task automatic send_flush();
		in_t it;
		it.cmd = CMD_FLUSH;
		it.button_levels = MASK_W'($urandom);
		it.now_ms = $urandom;
		flushes++;
		send_item(it);
	endtask

	// wait until every event is out and the scanner has gone quiet
	task automatic settle();
		push <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [WIN_W-1:0] win, logic [MASK_W-1:0] bound,
			logic [MASK_W-1:0] dbl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DOUBLE_WINDOW;
		cfg_data <= win;
		@(posedge clk);
		win_ms = win;
		cfg_index <= CFG_BOUND_MASK;
		cfg_data <= bound;
		@(posedge clk);
		bound_bits = bound;
		cfg_index <= CFG_DOUBLE_MASK;
		cfg_data <= dbl;
		@(posedge clk);
		double_bits = dbl;
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count);
		logic [TIME_W-1:0] step;
		logic [MASK_W-1:0] levels;
		int span;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 4) begin
				send_flush();
			end else begin
				span = win_ms;
				span = span + span / 2 + 2;
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: step = $urandom_range(120);
					6, 7:             step = $urandom_range(span);
					8:                step = $urandom;
					default:          step = -$urandom_range(1000, 1);
				endcase
				if ($urandom_range(19) == 0)
					levels = MASK_W'($urandom);
				else
					levels = live_levels ^ MASK_W'($urandom & $urandom);
				send_sample(levels, live_ms + step);
			end
		end
	endtask

	// ---------------- tests ----------------

	// nothing bound after reset: samples and flushes give no events
	task automatic test_reset_state();
		send_sample(16'hFFFF, 32'd10);
		send_sample(16'h0000, 32'd20);
		send_sample(16'hA5A5, 32'd30);
		send_flush();
		settle();
	endtask

	task automatic test_directed();
		write_cfg(16'd250, 16'hFFFF, 16'h00FF);
		send_sample(16'h0000, 32'h0000_0000);
		// single press without double action: press, hold, release
		send_sample(16'h0100, 32'd1000);
		send_sample(16'h0100, 32'd1010);
		send_sample(16'h0000, 32'd1020);
		// double press one ms inside the window
		send_sample(16'h0001, 32'd2000);
		send_sample(16'h0000, 32'd2050);
		send_sample(16'h0001, 32'd2249);
		send_sample(16'h0001, 32'd2260);
		send_sample(16'h0000, 32'd2270);
		// second tap exactly at the window edge, then held past the window
		send_sample(16'h0002, 32'd3000);
		send_sample(16'h0000, 32'd3100);
		send_sample(16'h0002, 32'd3250);
		send_sample(16'h0002, 32'd3600);
		send_sample(16'h0000, 32'd3610);
		// time going backwards expires the buffered taps
		send_sample(16'h000C, 32'd5000);
		send_sample(16'h0000, 32'd4000);
		// double press across the timestamp wrap
		send_sample(16'h0010, 32'hFFFF_FFF0);
		send_sample(16'h0000, 32'hFFFF_FFF8);
		send_sample(16'h0010, 32'h0000_0010);
		send_sample(16'hFFFF, 32'h0000_0020);
		send_flush();
		send_sample(16'hFFFF, 32'hFFFF_FFFF);
		send_flush();
		send_flush();
		settle();
	endtask

	task automatic test_zero_window();
		write_cfg(16'd0, 16'hFFFF, 16'hFFFF);
		run_random(140);
		settle();
	endtask

	task automatic test_full_window();
		write_cfg(16'hFFFF, MASK_W'($urandom) | 16'h8001, MASK_W'($urandom) | 16'h0003);
		run_random(140);
		settle();
	endtask

	// results held back long enough for the block to fill and stall its input
	task automatic test_backpressure();
		write_cfg(16'd100, 16'hFFFF, 16'h0000);
		-> start_long_stall;
		for (int i = 0; i < 24; i++)
			send_sample((i % 2 == 0) ? 16'hFFFF : 16'h0000, live_ms + 32'd500);
		settle();
	endtask

	task automatic test_mixed_settings();
		for (int k = 0; k < 3; k++) begin
			write_cfg(WIN_W'($urandom_range(400)), MASK_W'($urandom), MASK_W'($urandom));
			run_random(55);
			settle();
		end
	endtask

	initial begin
		clear_trackers();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		stall_pct = 88;
		test_reset_state();
		test_directed();
		test_zero_window();

		send_idle_pct = 88;
		stall_pct = 31;
		test_full_window();

		send_idle_pct = 0;
		stall_pct = 0;
		test_backpressure();
		test_mixed_settings();

		errors += pending_events.size();
		$display("Checked %0d events from %0d items (%0d flushes) over seven register settings,",
			events_checked, items_sent, flushes);
		$display("with idling on either side, none at all, and one long result stall.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/bpec_pkg.sv
src/bpec_fifo.sv
src/bpec_scan.sv
src/button_press_event_classifier_top.sv
verif/button_press_event_classifier_top_test.sv
